// File: hdl/binary_morphology_3x3_macros.svh
// Assertion macros for the binary_morphology_3x3 checker.
// Used by bm3_checker.sv; expects a clock named clk and a reset named rst in scope.
`ifndef BINARY_MORPHOLOGY_3X3_MACROS_SVH
`define BINARY_MORPHOLOGY_3X3_MACROS_SVH

// same-cycle implication, off while in reset
`define BM3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("binary_morphology_3x3 check failed");

// next-cycle implication, off while in reset
`define BM3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("binary_morphology_3x3 check failed");

// next-cycle implication that also watches the reset itself
`define BM3_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("binary_morphology_3x3 check failed");

`endif

// File: hdl/bm3_pkg.sv
// Shared constants, register indexes and inter-module structs for the
// 3x3 binary morphology block. No dependencies.
`timescale 1ns / 1ps

package bm3_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int MAX_ROWS  = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 12;   // frame_width register
  localparam int FH_W      = 13;   // frame_height register
  localparam int ROW_W     = 13;
  localparam int EMIT_W    = 23;
  localparam int WIN_BITS  = 9;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;

  localparam logic [WIN_BITS-1:0] KEEP_COLS = 9'h0DB;
  localparam logic [PIX_W-1:0]    FG_VALUE  = 8'd255;
  localparam logic [ROW_W-1:0]    ROW_SAT   = {ROW_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DILATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;

  // one accepted beat, decoded in the front stage
  typedef struct packed {
    logic             valid;
    logic             pix;
    logic [COL_W-1:0] col;
    logic             interior;
    logic             has_out;
    logic             last;
  } s0_beat_t;

  // settings the window stage needs
  typedef struct packed {
    logic [WIN_BITS-1:0] mask;
    logic                dilate;
    logic                restart;
  } win_cfg_t;

  // line memory write request
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [1:0]       data;
  } line_wr_t;

endpackage

// File: hdl/bm3_line_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No package dependency.
`timescale 1ns / 1ps

module bm3_line_ram #(
  parameter int DEPTH  = 2048,
  parameter int WIDTH  = 2,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/bm3_ctrl.sv
// Front stage: configuration registers, frame position counters, line memory
// read issue, write arbitration and the post-reset clearing pass. Uses bm3_pkg.
`timescale 1ns / 1ps

module bm3_ctrl import bm3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [PIX_W-1:0]     pixel_value,
  input  logic                 filler,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 s1_free,
  output s0_beat_t             s0,
  output win_cfg_t             wcfg,
  input  line_wr_t             line_wr,
  output line_wr_t             ram_wr,
  output logic                 rd_en,
  output logic [COL_W-1:0]     rd_addr
);

  logic [WIN_BITS-1:0] mask_bits;
  logic                dilate_mode;
  logic [FW_W-1:0]     eff_w;
  logic [FH_W-1:0]     eff_h;
  logic [EMIT_W-1:0]   last_idx;

  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [EMIT_W-1:0]   emitted_count;

  logic                clearing;
  logic [COL_W-1:0]    clr_addr;

  logic                accept;
  logic                geom_wr;
  logic [FW_W-1:0]     w_in;
  logic [FH_W-1:0]     h_in;
  logic [FW_W-1:0]     w_new;
  logic [FH_W-1:0]     h_new;
  logic [FW_W+FH_W-1:0] area;
  logic                col_wrap;
  logic                has_out;
  logic                interior;
  logic                last;

  assign accept  = in_valid && !in_stall;
  assign in_stall = clearing || !s1_free;
  assign geom_wr = cfg_write_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  // clamp incoming geometry, then the index of the frame's final result
  always_comb begin
    w_in = cfg_data[FW_W-1:0];
    h_in = cfg_data[FH_W-1:0];
    if (w_in < FW_W'(3)) begin
      w_in = FW_W'(3);
    end else if (w_in > FW_W'(MAX_WIDTH)) begin
      w_in = FW_W'(MAX_WIDTH);
    end
    if (h_in < FH_W'(3)) begin
      h_in = FH_W'(3);
    end else if (h_in > FH_W'(MAX_ROWS)) begin
      h_in = FH_W'(MAX_ROWS);
    end
    w_new = (cfg_index == REG_WIDTH)  ? w_in : eff_w;
    h_new = (cfg_index == REG_HEIGHT) ? h_in : eff_h;
    area  = (FW_W+FH_W)'(w_new) * (FW_W+FH_W)'(h_new);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_bits   <= {WIN_BITS{1'b1}};
      dilate_mode <= 1'b0;
      eff_w       <= FW_W'(640);
      eff_h       <= FH_W'(480);
      last_idx    <= EMIT_W'(640 * 480 - 1);
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MASK:   mask_bits <= cfg_data[WIN_BITS-1:0];
        REG_DILATE: dilate_mode <= cfg_data[0];
        REG_WIDTH: begin
          eff_w    <= w_in;
          last_idx <= EMIT_W'(area - 1'b1);
        end
        REG_HEIGHT: begin
          eff_h    <= h_in;
          last_idx <= EMIT_W'(area - 1'b1);
        end
        default: ;
      endcase
    end
  end

  // decode the position of the incoming beat
  always_comb begin
    has_out  = (row_count >= ROW_W'(2)) ||
               (row_count == ROW_W'(1) && column_count != '0);
    interior = (column_count >= COL_W'(2)) && (row_count >= ROW_W'(2)) &&
               (row_count < ROW_W'(eff_h));
    last     = has_out && (emitted_count >= last_idx);
    col_wrap = ({1'b0, column_count} + FW_W'(1)) == eff_w;
  end

  // frame position and result count
  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      column_count  <= '0;
      row_count     <= '0;
      emitted_count <= '0;
    end else if (accept) begin
      if (last) begin
        column_count  <= '0;
        row_count     <= '0;
        emitted_count <= '0;
      end else begin
        if (col_wrap) begin
          column_count <= '0;
          if (row_count != ROW_SAT) begin
            row_count <= row_count + 1'b1;
          end
        end else begin
          column_count <= column_count + 1'b1;
        end
        if (has_out) begin
          emitted_count <= emitted_count + 1'b1;
        end
      end
    end
  end

  // clearing pass over the line memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // beat to the window stage, memory read and write port
  always_comb begin
    s0.valid    = accept;
    s0.pix      = !filler && (pixel_value != '0);
    s0.col      = column_count;
    s0.interior = interior;
    s0.has_out  = has_out;
    s0.last     = last;

    wcfg.mask    = mask_bits;
    wcfg.dilate  = dilate_mode;
    wcfg.restart = geom_wr;

    rd_en   = accept;
    rd_addr = column_count;

    if (clearing) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_addr;
      ram_wr.data = 2'b00;
    end else begin
      ram_wr = line_wr;
    end
  end

endmodule

// File: hdl/bm3_window.sv
// Window stage: takes the line memory read data, shifts the 3x3 window,
// writes the column back and holds the output register. Uses bm3_pkg.
`timescale 1ns / 1ps

module bm3_window import bm3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  s0_beat_t         s0,
  input  win_cfg_t         wcfg,
  input  logic [1:0]       rd_data,
  output logic             s1_free,
  output line_wr_t         line_wr,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] result_pixel,
  output logic             frame_last
);

  s0_beat_t            s1;
  logic [WIN_BITS-1:0] window_bits;
  logic [WIN_BITS-1:0] win_next;
  logic [WIN_BITS-1:0] hit;
  logic                out_free;
  logic                s1_adv;
  logic                fg;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1.valid && out_free;
  assign s1_free  = !s1.valid || s1_adv;

  // shift in top (row before last), mid (last row) and the new pixel
  always_comb begin
    win_next = ((window_bits >> 1) & KEEP_COLS) |
               (WIN_BITS'(rd_data[1]) << 2) |
               (WIN_BITS'(rd_data[0]) << 5) |
               (WIN_BITS'(s1.pix) << 8);
    hit = win_next & wcfg.mask;
    if (!s1.interior) begin
      fg = 1'b0;
    end else if (wcfg.dilate) begin
      fg = (hit != '0);
    end else begin
      fg = (hit == wcfg.mask);
    end
    line_wr.en   = s1_adv;
    line_wr.addr = s1.col;
    line_wr.data = {rd_data[0], s1.pix};
  end

  // stage register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (s0.valid) begin
      s1.valid <= 1'b1;
    end else if (s1_adv) begin
      s1.valid <= 1'b0;
    end
    if (s0.valid) begin
      s1.pix      <= s0.pix;
      s1.col      <= s0.col;
      s1.interior <= s0.interior;
      s1.has_out  <= s0.has_out;
      s1.last     <= s0.last;
    end
  end

  // window, cleared at frame end and on geometry writes
  always_ff @(posedge clk) begin
    if (rst || wcfg.restart) begin
      window_bits <= '0;
    end else if (s1_adv) begin
      window_bits <= s1.last ? '0 : win_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1.has_out) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.has_out) begin
      result_pixel <= fg ? FG_VALUE : '0;
      frame_last   <= s1.last;
    end
  end

endmodule

// File: hdl/binary_morphology_3x3.sv
// 3x3 binary erosion/dilation over a raster pixel stream, 255/0 results.
// Throughput: one beat per cycle unless out_stall or the clearing pass holds
// the input; line memory read-modify-write at one column per beat sets this.
// A result leaves after the beat one row plus one pixel behind its pixel is
// taken (front stage, window stage). Reset: synchronous, then a line memory
// clear with in_stall high; configuration writes are taken throughout.
`timescale 1ns / 1ps

module binary_morphology_3x3 import bm3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel_value,
  input  logic                 filler,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     result_pixel,
  output logic                 frame_last
);

  s0_beat_t         s0;
  win_cfg_t         wcfg;
  line_wr_t         line_wr;
  line_wr_t         ram_wr;
  logic             s1_free;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  logic [1:0]       rd_data;

  bm3_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_value  (pixel_value),
    .filler       (filler),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .s1_free      (s1_free),
    .s0           (s0),
    .wcfg         (wcfg),
    .line_wr      (line_wr),
    .ram_wr       (ram_wr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  bm3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bm3_window u_window (
    .clk          (clk),
    .rst          (rst),
    .s0           (s0),
    .wcfg         (wcfg),
    .rd_data      (rd_data),
    .s1_free      (s1_free),
    .line_wr      (line_wr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_pixel (result_pixel),
    .frame_last   (frame_last)
  );

endmodule

// File: hdl/bm3_checker.sv
// Port-level checks for binary_morphology_3x3, bound to the top level.
// Uses bm3_pkg and binary_morphology_3x3_macros.svh.
`timescale 1ns / 1ps
`include "binary_morphology_3x3_macros.svh"

module bm3_checker import bm3_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] result_pixel,
  input logic             frame_last
);

  // results are only ever foreground or background
  `BM3_ASSERT_IMP(a_pix_code, out_valid, result_pixel == FG_VALUE || result_pixel == '0)

  // a stalled result beat stays put
  `BM3_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(result_pixel) && $stable(frame_last))

  // line memory clearing keeps the input closed right after reset
  `BM3_ASSERT_RST(a_rst_stall, rst, in_stall)

  // nothing comes out right after reset
  `BM3_ASSERT_RST(a_rst_quiet, rst, !out_valid)

endmodule

bind binary_morphology_3x3 bm3_checker u_bm3_checker (.*);
